/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the slot tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/rqst_pkg.sv */
// ----------------------------------------------------------------------------
// rqst_pkg
// Types, sizes and codes shared by the request slot tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rqst_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OP_W    = 3;
  localparam int ID_W    = 32;
  localparam int FAULT_W = 16;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 32;

  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK_PEND = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK_DONE = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK_ERR  = 3'd3;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd5;

  localparam logic [ST_W-1:0] ST_IDLE     = 2'd0;
  localparam logic [ST_W-1:0] ST_PENDING  = 2'd1;
  localparam logic [ST_W-1:0] ST_COMPLETE = 2'd2;
  localparam logic [ST_W-1:0] ST_ERROR    = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [ID_W-1:0]           target_id;
    logic signed [FAULT_W-1:0] fault_code;
  } rqst_in_t;

  typedef struct packed {
    logic                      ok;
    logic [ID_W-1:0]           granted_id;
    logic [ST_W-1:0]           slot_state;
    logic signed [FAULT_W-1:0] stored_fault;
    logic [CNT_W-1:0]          total_count;
    logic [CNT_W-1:0]          full_count;
    logic [CNT_W-1:0]          pending_count;
    logic [CNT_W-1:0]          completed_count;
    logic [CNT_W-1:0]          error_count;
  } rqst_out_t;

  typedef struct packed {
    logic capture;
    logic apply;
  } rqst_cmd_t;

endpackage

`default_nettype wire

/* src/request_slot_tracker.sv */
// On the accepting edge the controller enters S_APPLY; out_valid and out_item are registered as it leaves S_APPLY.
// A new request is accepted only while busy is low; the slot table is searched in the
//   accept cycle and written back in the following cycle, when busy is high.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low): all slots idle, next ID 1, counters zero.
// ----------------------------------------------------------------------------
// request_slot_tracker
// Table of outstanding request slots with ID allocation and statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module request_slot_tracker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  rqst_pkg::rqst_in_t    in_item,
  output logic                  out_valid,
  output rqst_pkg::rqst_out_t   out_item
);
  import rqst_pkg::*;

  rqst_cmd_t cmd;

  rqst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rqst_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

/* src/rqst_ctrl.sv */
// ----------------------------------------------------------------------------
// rqst_ctrl
// Sequencer: search on accept, write back in the next cycle, strobe result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rqst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    out_valid,
  output rqst_pkg::rqst_cmd_t     cmd
);
  import rqst_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic state_r;
  logic state_nxt;
  logic valid_r;
  logic accept;

  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == S_APPLY);
    end
  end

  assign busy        = (state_r == S_APPLY);
  assign out_valid   = valid_r;
  assign cmd.capture = accept;
  assign cmd.apply   = (state_r == S_APPLY);

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_NEXT(a_apply_one_cycle, clk, rst_n, busy, !busy && out_valid)
  `ASSERT_IMP(a_valid_after_apply, clk, rst_n, out_valid, !busy)

endmodule

`default_nettype wire

/* src/rqst_dp.sv */
// ----------------------------------------------------------------------------
// rqst_dp
// Slot table, parallel search and priority pick, write-back and statistics.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rqst_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  rqst_pkg::rqst_cmd_t      cmd,
  input  rqst_pkg::rqst_in_t       in_item,
  output rqst_pkg::rqst_out_t      out_item
);
  import rqst_pkg::*;

  logic [ST_W-1:0]    status_r [SLOTS];
  logic [ID_W-1:0]    ident_r  [SLOTS];
  logic [FAULT_W-1:0] fault_r  [SLOTS];

  logic [ID_W-1:0]    next_id_r,   next_id_nxt;
  logic [CNT_W-1:0]   total_r,     total_nxt;
  logic [CNT_W-1:0]   full_r,      full_nxt;
  logic [CNT_W-1:0]   pend_r,      pend_nxt;
  logic [CNT_W-1:0]   done_r,      done_nxt;
  logic [CNT_W-1:0]   err_r,       err_nxt;

  logic [OP_W-1:0]    op_r;
  logic [FAULT_W-1:0] code_r;
  logic [SLOT_W-1:0]  sel_r;
  logic               hit_r;
  rqst_out_t          res_r;

  logic               idle_hit, match_hit;
  logic [SLOT_W-1:0]  idle_sel, match_sel;

  logic [ST_W-1:0]    cur_st;
  logic [FAULT_W-1:0] cur_fault;
  logic               wr_en, wr_id_en, wr_fault_en;
  logic [ST_W-1:0]    wr_st;
  logic [ID_W-1:0]    wr_id;
  logic [FAULT_W-1:0] wr_fault;
  logic [CNT_W-1:0]   pend_dn;
  rqst_out_t          res_nxt;

  // priority pick: lowest idle slot, lowest live slot with matching ID
  always_comb begin
    idle_hit  = 1'b0;
    idle_sel  = '0;
    match_hit = 1'b0;
    match_sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (status_r[i] == ST_IDLE) begin
        idle_hit = 1'b1;
        idle_sel = SLOT_W'(i);
      end
      if (status_r[i] != ST_IDLE && ident_r[i] == in_item.target_id) begin
        match_hit = 1'b1;
        match_sel = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_item.operation;
      code_r <= in_item.fault_code;
      if (in_item.operation == OP_ALLOC) begin
        sel_r <= idle_sel;
        hit_r <= idle_hit;
      end else begin
        sel_r <= match_sel;
        hit_r <= match_hit && (in_item.target_id != '0) &&
                 (in_item.operation inside {[OP_MARK_PEND:OP_QUERY]});
      end
    end
  end

  assign cur_st    = status_r[sel_r];
  assign cur_fault = fault_r[sel_r];
  assign pend_dn   = (pend_r != '0) ? pend_r - CNT_W'(1) : pend_r;

  always_comb begin
    wr_en       = 1'b0;
    wr_st       = cur_st;
    wr_id_en    = 1'b0;
    wr_id       = next_id_r;
    wr_fault_en = 1'b0;
    wr_fault    = code_r;
    next_id_nxt = next_id_r;
    total_nxt   = total_r;
    full_nxt    = full_r;
    pend_nxt    = pend_r;
    done_nxt    = done_r;
    err_nxt     = err_r;
    if (cmd.apply && hit_r) begin
      case (op_r)
        OP_ALLOC: begin
          wr_en       = 1'b1;
          wr_st       = ST_PENDING;
          wr_id_en    = 1'b1;
          wr_fault_en = 1'b1;
          wr_fault    = '0;
          next_id_nxt = (next_id_r == '1) ? ID_W'(1) : next_id_r + ID_W'(1);
          total_nxt   = total_r + CNT_W'(1);
        end
        OP_MARK_PEND: begin
          wr_en    = 1'b1;
          wr_st    = ST_PENDING;
          pend_nxt = pend_r + CNT_W'(1);
        end
        OP_MARK_DONE: begin
          wr_en    = 1'b1;
          wr_st    = ST_COMPLETE;
          pend_nxt = pend_dn;
          done_nxt = done_r + CNT_W'(1);
        end
        OP_MARK_ERR: begin
          wr_en       = 1'b1;
          wr_st       = ST_ERROR;
          wr_fault_en = 1'b1;
          pend_nxt    = pend_dn;
          err_nxt     = err_r + CNT_W'(1);
        end
        OP_FREE: begin
          wr_en    = 1'b1;
          wr_st    = ST_IDLE;
          wr_id_en = 1'b1;
          wr_id    = '0;
          if (cur_st == ST_PENDING) pend_nxt = pend_dn;
        end
        default: begin
        end
      endcase
    end else if (cmd.apply && op_r == OP_ALLOC) begin
      full_nxt = full_r + CNT_W'(1);
    end
  end

  always_comb begin
    res_nxt                 = '0;
    res_nxt.ok              = hit_r;
    res_nxt.granted_id      = (hit_r && op_r == OP_ALLOC) ? next_id_r : '0;
    res_nxt.slot_state      = hit_r ? wr_st : ST_IDLE;
    res_nxt.stored_fault    = hit_r ? (wr_fault_en ? wr_fault : cur_fault) : '0;
    res_nxt.total_count     = total_nxt;
    res_nxt.full_count      = full_nxt;
    res_nxt.pending_count   = pend_nxt;
    res_nxt.completed_count = done_nxt;
    res_nxt.error_count     = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) status_r[i] <= ST_IDLE;
      next_id_r <= ID_W'(1);
      total_r   <= '0;
      full_r    <= '0;
      pend_r    <= '0;
      done_r    <= '0;
      err_r     <= '0;
    end else begin
      if (wr_en) status_r[sel_r] <= wr_st;
      next_id_r <= next_id_nxt;
      total_r   <= total_nxt;
      full_r    <= full_nxt;
      pend_r    <= pend_nxt;
      done_r    <= done_nxt;
      err_r     <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_id_en) ident_r[sel_r] <= wr_id;
    if (wr_fault_en) fault_r[sel_r] <= wr_fault;
    if (cmd.apply) res_r <= res_nxt;
  end

  assign out_item = res_r;

  `ASSERT_IMP(a_next_id_nonzero, clk, rst_n, 1'b1, next_id_r != '0)
  `ASSERT_IMP(a_alloc_hits_idle, clk, rst_n, cmd.apply && hit_r && op_r == OP_ALLOC,
              cur_st == ST_IDLE)
  `ASSERT_IMP(a_lookup_hits_live, clk, rst_n, cmd.apply && hit_r && op_r != OP_ALLOC,
              cur_st != ST_IDLE)

endmodule

`default_nettype wire
